/* hw/rtl/ffac_pkg.sv */
`timescale 1ns / 1ps
package ffac_pkg;

  // Field widths fixed by the request and result formats.
  localparam int ADDR_W  = 7;
  localparam int XFER_W  = 32;
  localparam int CFG_W   = 4;
  localparam int COUNT_W = 32;

  // Reset value of the ways-in-use register.
  localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_FETCH      = 2'd1,
    CMD_DATA_WRITE = 2'd2,
    CMD_PROG_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_OPERAND = 2'd1,
    KIND_INSTR   = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // request taken: latch it, start backing-store reads
    logic commit;  // execute the latched request, load the result register
  } ctl_cmd_t;

endpackage

/* hw/rtl/ffac_if.sv */
`timescale 1ns / 1ps
interface ffac_req_if
  import ffac_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [ADDR_W-1:0]        address;
  logic signed [XFER_W-1:0] write_data;

  modport source (output valid, cmd, address, write_data, input ready);
  modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

interface ffac_rsp_if
  import ffac_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [XFER_W-1:0] read_data;
  logic                     was_hit;
  logic                     address_error;
  logic [COUNT_W-1:0]       hit_count;
  logic [COUNT_W-1:0]       miss_count;
  logic [COUNT_W-1:0]       access_count;

  modport source (output valid, read_data, was_hit, address_error, hit_count, miss_count,
                  access_count, input ready);
  modport sink   (input valid, read_data, was_hit, address_error, hit_count, miss_count,
                  access_count, output ready);
endinterface

/* hw/rtl/ffac_ctrl.sv */
`timescale 1ns / 1ps
module ffac_ctrl
  import ffac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t ctl
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  assign ctl.load   = in_valid && in_ready;
  assign ctl.commit = (state == ST_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (ctl.load) begin
            state    <= ST_EXEC;
            in_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          // hold until the result register is free
          if (ctl.commit) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ffac_dpath.sv */
`timescale 1ns / 1ps
module ffac_dpath
  import ffac_pkg::*;
#(
  parameter int DATA_DEPTH    = 128,
  parameter int PROGRAM_DEPTH = 64,
  parameter int CACHE_DEPTH   = 8,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_cmd_t                  ctl,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic [1:0]                cmd,
  input  logic [ADDR_W-1:0]         address,
  input  logic signed [XFER_W-1:0]  write_data,
  output logic signed [XFER_W-1:0]  read_data,
  output logic                      was_hit,
  output logic                      address_error,
  output logic [COUNT_W-1:0]        hit_count,
  output logic [COUNT_W-1:0]        miss_count,
  output logic [COUNT_W-1:0]        access_count
);

  localparam int DAW    = $clog2(DATA_DEPTH);
  localparam int PAW    = $clog2(PROGRAM_DEPTH);
  localparam int PTR_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int WAYS_W = $clog2(CACHE_DEPTH + 1);

  // Latched request
  cmd_t                  req_cmd;
  logic [ADDR_W-1:0]     req_addr;
  logic [WORD_WIDTH-1:0] req_word;

  // Backing stores and their registered read data
  logic [WORD_WIDTH-1:0] data_mem [DATA_DEPTH];
  logic [WORD_WIDTH-1:0] prog_mem [PROGRAM_DEPTH];
  logic [WORD_WIDTH-1:0] data_rd;
  logic [WORD_WIDTH-1:0] prog_rd;

  // Cache entries
  kind_t                 entry_kind [CACHE_DEPTH];
  logic [ADDR_W-1:0]     entry_addr [CACHE_DEPTH];
  logic [WORD_WIDTH-1:0] entry_val  [CACHE_DEPTH];
  logic [PTR_W-1:0]      ins_ptr;
  logic [CFG_W-1:0]      ways;

  logic [COUNT_W-1:0]    hit_cnt;
  logic [COUNT_W-1:0]    miss_cnt;
  logic [COUNT_W-1:0]    acc_cnt;

  // Index and width conversions
  logic [WORD_WIDTH+XFER_W-1:0] in_wide;
  logic [WORD_WIDTH+XFER_W-1:0] out_wide;
  logic [DAW+ADDR_W-1:0]        d_ext;
  logic [DAW+ADDR_W-1:0]        rd_ext;
  logic [PAW+ADDR_W-1:0]        p_ext;
  logic [PAW+ADDR_W-1:0]        rp_ext;
  logic [WAYS_W+CFG_W-1:0]      ways_ext;

  logic [WAYS_W-1:0]     eff_ways;
  logic                  data_ok;
  logic                  prog_ok;
  logic                  do_lookup;
  kind_t                 look_kind;
  logic [WORD_WIDTH-1:0] backing;
  logic                  err;
  logic                  dwrite;
  logic                  pwrite;
  logic [CACHE_DEPTH-1:0] way_match;
  logic                  hit;
  logic [PTR_W-1:0]      hit_idx;
  logic [PTR_W-1:0]      slot;
  logic [PTR_W-1:0]      ptr_next;
  logic                  look_hit;
  logic                  look_miss;
  logic [WORD_WIDTH-1:0] rdata_word;

  assign in_wide  = {{WORD_WIDTH{1'b0}}, write_data};
  assign d_ext    = {{DAW{1'b0}}, address};
  assign rd_ext   = {{DAW{1'b0}}, req_addr};
  assign p_ext    = {{PAW{1'b0}}, address};
  assign rp_ext   = {{PAW{1'b0}}, req_addr};
  assign ways_ext = {{WAYS_W{1'b0}}, ways};

  assign data_ok = int'(req_addr) < DATA_DEPTH;
  assign prog_ok = int'(req_addr) < PROGRAM_DEPTH;

  // Zero acts as one, anything above the cache size as the cache size
  always_comb begin
    if (ways == '0) begin
      eff_ways = WAYS_W'(1);
    end else if (int'(ways) > CACHE_DEPTH) begin
      eff_ways = WAYS_W'(CACHE_DEPTH);
    end else begin
      eff_ways = ways_ext[WAYS_W-1:0];
    end
  end

  always_comb begin
    do_lookup = 1'b0;
    look_kind = KIND_OPERAND;
    backing   = '0;
    err       = 1'b0;
    dwrite    = 1'b0;
    pwrite    = 1'b0;
    case (req_cmd)
      CMD_READ: begin
        do_lookup = 1'b1;
        backing   = data_ok ? data_rd : '0;
      end
      CMD_FETCH: begin
        if (!prog_ok) begin
          err = 1'b1;
        end else begin
          do_lookup = 1'b1;
          look_kind = KIND_INSTR;
          backing   = prog_rd;
        end
      end
      CMD_DATA_WRITE: begin
        dwrite = data_ok;
      end
      CMD_PROG_WRITE: begin
        if (!prog_ok) begin
          err = 1'b1;
        end else begin
          pwrite = 1'b1;
        end
      end
      default: begin
        err = 1'b0;
      end
    endcase
  end

  // Parallel tag compare over the ways in use; lowest way wins
  always_comb begin
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      way_match[i] = (i < int'(eff_ways)) && (entry_kind[i] == look_kind) &&
                     (entry_addr[i] == req_addr);
    end
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (way_match[i]) begin
        hit     = 1'b1;
        hit_idx = PTR_W'(i);
      end
    end
  end

  assign slot     = (int'(ins_ptr) < int'(eff_ways)) ? ins_ptr : '0;
  assign ptr_next = (int'(slot) + 1 >= int'(eff_ways)) ? '0 : PTR_W'(int'(slot) + 1);

  assign look_hit   = do_lookup && hit;
  assign look_miss  = do_lookup && !hit;
  assign rdata_word = !do_lookup ? '0 : (hit ? entry_val[hit_idx] : backing);
  assign out_wide   = {{XFER_W{1'b0}}, rdata_word};

  // Backing stores
  always_ff @(posedge clk) begin
    if (ctl.commit && dwrite) begin
      data_mem[rd_ext[DAW-1:0]] <= req_word;
    end
    if (ctl.load) begin
      data_rd <= data_mem[d_ext[DAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && pwrite) begin
      prog_mem[rp_ext[PAW-1:0]] <= req_word;
    end
    if (ctl.load) begin
      prog_rd <= prog_mem[p_ext[PAW-1:0]];
    end
  end

  // Control state: entry kinds, insert pointer, counters, ways register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        entry_kind[i] <= KIND_EMPTY;
      end
      ins_ptr  <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
      acc_cnt  <= '0;
      ways     <= WAYS_RESET;
    end else begin
      if (cfg_we) begin
        ways <= cfg_wdata;
      end
      if (ctl.commit) begin
        hit_cnt  <= hit_cnt + COUNT_W'(look_hit);
        miss_cnt <= miss_cnt + COUNT_W'(look_miss);
        acc_cnt  <= acc_cnt + COUNT_W'(do_lookup);
        if (look_miss) begin
          entry_kind[slot] <= look_kind;
          ins_ptr          <= ptr_next;
        end
      end
    end
  end

  // Payload: request latch, entry tags and words, result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd  <= cmd_t'(cmd);
      req_addr <= address;
      req_word <= in_wide[WORD_WIDTH-1:0];
    end
    if (ctl.commit) begin
      if (look_miss) begin
        entry_addr[slot] <= req_addr;
        entry_val[slot]  <= backing;
      end
      if (pwrite) begin
        // keep cached instructions coherent with the program store
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (entry_kind[i] == KIND_INSTR && entry_addr[i] == req_addr) begin
            entry_val[i] <= req_word;
          end
        end
      end
      read_data     <= out_wide[XFER_W-1:0];
      was_hit       <= look_hit;
      address_error <= err;
    end
  end

  // Counters change only at commit, together with the result register
  assign hit_count    = hit_cnt;
  assign miss_count   = miss_cnt;
  assign access_count = acc_cnt;

endmodule

/* hw/rtl/fifo_fully_associative_cache.sv */
`timescale 1ns / 1ps
// Fully associative cache with FIFO replacement, shared by operand reads and
// instruction fetches, in front of a data store and a program store. Every
// request has an accept step, which latches it and issues the synchronous
// backing-store reads, and an execute step, which compares all tags in
// parallel, fills a way on a miss, updates the counters and loads the result
// register. A new request is accepted the cycle after that at the earliest, so
// the cache does not take a request before it is through with the last one. A
// result that is not taken holds the execute step of the following request; the
// request after that waits. Data writes touch only the data store (a cached
// operand may go stale); program writes also update any cached copy of that
// instruction. The cache is cleared at reset; the stores come up undefined and
// must be written before they are read. Write ways_in_use only while no request
// is in flight.
module fifo_fully_associative_cache
  import ffac_pkg::*;
#(
  parameter int DATA_DEPTH    = 128,
  parameter int PROGRAM_DEPTH = 64,
  parameter int CACHE_DEPTH   = 8,
  parameter int WORD_WIDTH    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  ffac_req_if.sink         request,
  ffac_rsp_if.source       result
);

  ctl_cmd_t ctl;

  // Sequence each request: accept, then execute into the result register
  ffac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // Hold the stores, the cache ways, the counters and the result
  ffac_dpath #(
    .DATA_DEPTH    (DATA_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .CACHE_DEPTH   (CACHE_DEPTH),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (request.cmd),
    .address       (request.address),
    .write_data    (request.write_data),
    .read_data     (result.read_data),
    .was_hit       (result.was_hit),
    .address_error (result.address_error),
    .hit_count     (result.hit_count),
    .miss_count    (result.miss_count),
    .access_count  (result.access_count)
  );

  // A request is latched and executed in different cycles
  a_load_commit_apart: assert property (@(posedge clk) disable iff (rst)
    !(ctl.load && ctl.commit))
    else $error("request latched and executed in the same cycle");

  // Executing a request always presents a result next cycle
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> result.valid)
    else $error("executed request left no result");

  // Every read or fetch is either a hit or a miss
  a_counts_add_up: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.hit_count + result.miss_count == result.access_count))
    else $error("hit and miss counts do not add up to access count");

  // A flagged request never hits
  a_error_no_hit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.address_error |-> !result.was_hit)
    else $error("address error reported together with a hit");

endmodule
